/* src/sdrs_pkg.sv */
// shared types and constants of the scan disk request scheduler
// no dependencies
package sdrs_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_W        = 16;
  localparam int MOVE_W       = CYL_W + 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  localparam logic [CYL_W-1:0]  TOP_DEFAULT = CYL_W'(4999);
  localparam logic [MOVE_W-1:0] MOVE_MAX    = {MOVE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_POSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREVIOUS_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYLINDER  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_HEAD,
    ST_SWEEP1,
    ST_END,
    ST_SWEEP2
  } back_state_e;

  typedef struct packed {
    logic [CYL_W-1:0] cyl;
    logic             last;
    logic             drop;
  } req_word_t;

  typedef struct packed {
    logic      valid;
    req_word_t word;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic done;
  } back_ctrl_t;

  typedef struct packed {
    logic [CYL_W-1:0] head_position;
    logic [CYL_W-1:0] previous_head;
    logic [CYL_W-1:0] max_cylinder;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CYL_W-1:0]  cyl;
    logic [MOVE_W-1:0] move;
    logic              last;
    logic              ovf;
  } result_t;

endpackage

/* src/scan_disk_request_scheduler.sv */
// top level of the scan disk request scheduler: config registers, front and back
// depends on sdrs_pkg, sdrs_front, sdrs_back
//
// channel   direction  handshake             word
// request   in         start high, busy low  request_cylinder_i, last_request_i
// result    out        result_strobe_o       service_cylinder_o, total_movement_o,
//                                            schedule_end_o, overflow_o
// config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// a request is written into the queue and then inserted in the cell chain when the back pops it
// after the last request: a scan for the split point, then one result a cycle
// for request count + 2 results; busy is high from the last request to the final result
// reset clears the queue, cell valid bits, counts and sets the registers to defaults
// results cannot be held off; busy also rises when the two word queue is full
module scan_disk_request_scheduler
  import sdrs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CYL_W-1:0]     request_cylinder_i,
  input  logic                 last_request_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CYL_W-1:0]     cfg_wdata_i,
  output logic                 result_strobe_o,
  output logic [CYL_W-1:0]     service_cylinder_o,
  output logic [MOVE_W-1:0]    total_movement_o,
  output logic                 schedule_end_o,
  output logic                 overflow_o
);

  cfg_t       cfg_q;
  queue_out_t queue;
  back_ctrl_t ctrl;
  result_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_position <= '0;
      cfg_q.previous_head <= '0;
      cfg_q.max_cylinder  <= TOP_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAD_POSITION: cfg_q.head_position <= cfg_wdata_i;
        REG_PREVIOUS_HEAD: cfg_q.previous_head <= cfg_wdata_i;
        REG_MAX_CYLINDER:  cfg_q.max_cylinder  <= cfg_wdata_i;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  sdrs_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .request_cylinder_i (request_cylinder_i),
    .last_request_i     (last_request_i),
    .ctrl_i             (ctrl),
    .queue_o            (queue)
  );

  sdrs_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .queue_i  (queue),
    .ctrl_o   (ctrl),
    .result_o (result)
  );

  assign result_strobe_o    = result.valid;
  assign service_cylinder_o = result.cyl;
  assign total_movement_o   = result.move;
  assign schedule_end_o     = result.last;
  assign overflow_o         = result.ovf;

endmodule

/* src/sdrs_front.sv */
// front part: takes request words, marks drops beyond capacity, queues them
// depends on sdrs_pkg
module sdrs_front
  import sdrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CYL_W-1:0] request_cylinder_i,
  input  logic             last_request_i,
  input  back_ctrl_t       ctrl_i,
  output queue_out_t       queue_o
);

  req_word_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  batch_cnt_q, batch_cnt_d;
  logic              hold_q, hold_d;
  logic              push, pop, drop;
  req_word_t         word_in;

  assign busy = (fill_q == QCNT_W'(QUEUE_DEPTH)) || hold_q;
  assign push = start && !busy;
  assign pop  = ctrl_i.pop && (fill_q != '0);
  assign drop = (batch_cnt_q == CNT_W'(MAX_REQUESTS));

  assign word_in.cyl  = request_cylinder_i;
  assign word_in.last = last_request_i;
  assign word_in.drop = drop;

  assign queue_o.valid = (fill_q != '0);
  assign queue_o.word  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    fill_d      = fill_q;
    batch_cnt_d = batch_cnt_q;
    hold_d      = hold_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
      if (last_request_i) begin
        batch_cnt_d = '0;
        hold_d      = 1'b1;
      end else if (!drop) begin
        batch_cnt_d = batch_cnt_q + 1'b1;
      end
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
    if (ctrl_i.done) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      batch_cnt_q <= '0;
      hold_q      <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      batch_cnt_q <= batch_cnt_d;
      hold_q      <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_in;
    end
  end

endmodule

/* src/sdrs_back.sv */
// back part: sorted cell chain and scan order sequencer with movement sum
// depends on sdrs_pkg
module sdrs_back
  import sdrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  queue_out_t queue_i,
  output back_ctrl_t ctrl_o,
  output result_t    result_o
);

  logic [CYL_W-1:0]        cells_q [MAX_REQUESTS];
  logic [CYL_W-1:0]        cells_ins [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] cell_valid_q, cell_valid_d;
  logic [MAX_REQUESTS-1:0] gt;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    dropped_q, dropped_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CYL_W-1:0]        pos_q;
  logic [MOVE_W-1:0]       moved_q;
  back_state_e             state_q, state_d;
  result_t                 res_q;

  logic              down, pop, insert, scan_hit, done;
  logic              emit, emit_last;
  logic [CYL_W-1:0]  emit_cyl, base_pos, cyl_rd, scan_cell, last_cell, top;
  logic [MOVE_W-1:0] base_move, move_new;
  logic [CYL_W-1:0]  delta;
  logic [MOVE_W:0]   move_sum;
  logic [CNT_W-1:0]  n_m1;
  logic              sw1_end, sw2_end, sw1_empty, sw2_empty;

  assign down      = (cfg_i.head_position < cfg_i.previous_head);
  assign pop       = (state_q == ST_LOAD) && queue_i.valid;
  assign insert    = pop && !queue_i.word.drop;
  assign n_m1      = count_q - 1'b1;
  assign cyl_rd    = cells_q[idx_q[IDX_W-1:0]];
  assign scan_cell = cells_q[k_q[IDX_W-1:0]];
  assign last_cell = cells_q[n_m1[IDX_W-1:0]];

  assign scan_hit = (k_q < count_q) &&
                    (down ? (scan_cell <= cfg_i.head_position)
                          : (scan_cell < cfg_i.head_position));

  assign sw1_empty = down ? (k_q == '0) : (k_q == count_q);
  assign sw2_empty = down ? (k_q == count_q) : (k_q == '0);
  assign sw1_end   = down ? (idx_q == '0) : (idx_q == n_m1);
  assign sw2_end   = down ? (idx_q == n_m1) : (idx_q == '0);

  // sorted insertion, each cell looks at itself and its lower neighbor
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      gt[i] = cell_valid_q[i] && (cells_q[i] > queue_i.word.cyl);
    end
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (gt[i] || (count_q == CNT_W'(i))) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cells_ins[i] = cells_q[(i > 0) ? i - 1 : 0];
        end else begin
          cells_ins[i] = queue_i.word.cyl;
        end
      end else begin
        cells_ins[i] = cells_q[i];
      end
    end
  end

  // sweep end of an upward pass
  always_comb begin
    top = cfg_i.max_cylinder;
    if (cfg_i.head_position > top) begin
      top = cfg_i.head_position;
    end
    if ((count_q != '0) && (last_cell > top)) begin
      top = last_cell;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (pop && queue_i.word.last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_hit) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        state_d = sw1_empty ? ST_END : ST_SWEEP1;
      end
      ST_SWEEP1: begin
        if (sw1_end) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        state_d = sw2_empty ? ST_LOAD : ST_SWEEP2;
      end
      ST_SWEEP2: begin
        if (sw2_end) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    emit      = 1'b0;
    emit_cyl  = cyl_rd;
    emit_last = 1'b0;
    base_pos  = pos_q;
    base_move = moved_q;
    unique case (state_q)
      ST_HEAD: begin
        emit      = 1'b1;
        emit_cyl  = cfg_i.head_position;
        base_pos  = cfg_i.head_position;
        base_move = '0;
      end
      ST_SWEEP1: begin
        emit = 1'b1;
      end
      ST_END: begin
        emit      = 1'b1;
        emit_cyl  = down ? '0 : top;
        emit_last = sw2_empty;
      end
      ST_SWEEP2: begin
        emit      = 1'b1;
        emit_last = sw2_end;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    done = emit_last;
  end

  assign delta    = (emit_cyl >= base_pos) ? (emit_cyl - base_pos) : (base_pos - emit_cyl);
  assign move_sum = {1'b0, base_move} + {{(MOVE_W + 1 - CYL_W){1'b0}}, delta};
  assign move_new = (move_sum > {1'b0, MOVE_MAX}) ? MOVE_MAX : move_sum[MOVE_W-1:0];

  // bookkeeping
  always_comb begin
    count_d      = count_q;
    cell_valid_d = cell_valid_q;
    dropped_d    = dropped_q;
    k_d          = k_q;
    idx_d        = idx_q;
    unique case (state_q)
      ST_LOAD: begin
        k_d = '0;
        if (pop && queue_i.word.drop) begin
          dropped_d = 1'b1;
        end
        if (insert) begin
          cell_valid_d[count_q[IDX_W-1:0]] = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          k_d = k_q + 1'b1;
        end
      end
      ST_HEAD: begin
        idx_d = down ? (k_q - 1'b1) : k_q;
      end
      ST_SWEEP1: begin
        idx_d = down ? (idx_q - 1'b1) : (idx_q + 1'b1);
      end
      ST_END: begin
        idx_d = down ? k_q : (k_q - 1'b1);
      end
      ST_SWEEP2: begin
        idx_d = down ? (idx_q + 1'b1) : (idx_q - 1'b1);
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
    if (done) begin
      count_d      = '0;
      cell_valid_d = '0;
      dropped_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      cell_valid_q <= '0;
      dropped_q    <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      cell_valid_q <= cell_valid_d;
      dropped_q    <= dropped_d;
      res_q.valid  <= emit;
      if (emit) begin
        res_q.cyl  <= emit_cyl;
        res_q.move <= move_new;
        res_q.last <= emit_last;
        res_q.ovf  <= dropped_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    idx_q <= idx_d;
    if (insert) begin
      for (int i = 0; i < MAX_REQUESTS; i++) begin
        cells_q[i] <= cells_ins[i];
      end
    end
    if (emit) begin
      pos_q   <= emit_cyl;
      moved_q <= move_new;
    end
  end

  assign ctrl_o.pop  = pop;
  assign ctrl_o.done = done;
  assign result_o    = res_q;

endmodule
